// File: rtl/lkvc_pkg.sv
package lkvc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;
	localparam int DATA_W      = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_TOUCH,
		ST_DONE
	} lkvc_state_t;

	// per-state controls from the sequencer decode
	typedef struct packed {
		logic in_ready;
		logic scan;
		logic decide;
		logic touch;
		logic done;
	} lkvc_ctrl_t;

endpackage

// File: rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement. Each input
// transfer is a get (op=0) or a put (op=1) of a 32-bit key; every one yields exactly one
// output transfer: found, read_value (stored value, -1 on a get miss, the written value
// on a put) and evicted. Recency is a rank per entry (0 = most recent) held in a RAM next
// to the key and data RAMs; valid bits are flops and clear at reset, so no clearing pass
// is needed. One item runs under a small sequencer: a scan pass reads one entry per cycle
// through the single key comparator, a decide step, then a rank update pass over the age
// RAM (skipped on a get miss), and a done state that loads the output register; both
// passes are set by the one-read-per-cycle port of the entry RAMs. in_ready is high only
// when no item is in progress; a finished result waits in the output register while the
// next item is accepted. capacity (written through cfg_we/cfg_wdata while idle) of 0 acts
// as 1 and values above ENTRIES act as ENTRIES; lowering it below the current occupancy
// keeps entries and makes every new put evict.
module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [DATA_W-1:0] read_value,
	output logic              evicted
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // entry index / rank width
	localparam int CW = $clog2(ENTRIES + 1);                    // counts up to ENTRIES
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;              // capacity compare width
	localparam logic [CW-1:0] LAST = CW'(ENTRIES);

	lkvc_state_t state_q, state_nxt;
	lkvc_ctrl_t  ctrl;

	logic [CAP_W-1:0]   capacity_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      occ_q;
	logic [CW-1:0]      cnt_q;

	// latched item
	logic              op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;

	// read pipeline stage
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	// scan results
	logic          hit_q, free_any_q, old_any_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [IW-1:0] hit_age_q, old_age_q;

	// touch control
	logic [IW-1:0] slot_q;
	logic [IW-1:0] thr_q;
	logic          touch_all_q;

	// result / output registers
	logic              res_found_q, res_evict_q;
	logic [DATA_W-1:0] res_value_q;
	logic              out_valid_q, out_found_q, out_evict_q;
	logic [DATA_W-1:0] out_value_q;

	// RAM ports
	logic [DATA_W-1:0] key_rdata, data_rdata;
	logic [IW-1:0]     age_rdata;
	logic [IW-1:0]     rd_addr;
	logic              age_we;
	logic [IW-1:0]     age_wdata;

	// decide-cycle logic
	logic [XW-1:0] eff_cap;
	logic          put_new, evict, need_touch;
	logic [IW-1:0] slot_sel;
	logic          issue, cnt_last;

	assign issue    = (cnt_q < LAST);
	assign cnt_last = (cnt_q == LAST);
	assign rd_addr  = cnt_q[IW-1:0];

	always_comb begin
		priority if (capacity_q == '0) begin
			eff_cap = XW'(1);
		end else if (XW'(capacity_q) > XW'(ENTRIES)) begin
			eff_cap = XW'(ENTRIES);
		end else begin
			eff_cap = XW'(capacity_q);
		end
	end

	assign put_new    = (op_q == OP_PUT) && !hit_q && free_any_q && (XW'(occ_q) < eff_cap);
	assign evict      = (op_q == OP_PUT) && !hit_q && !put_new;
	assign need_touch = hit_q || (op_q == OP_PUT);

	always_comb begin
		priority if (hit_q) begin
			slot_sel = hit_idx_q;
		end else if (put_new) begin
			slot_sel = free_idx_q;
		end else begin
			slot_sel = old_idx_q;
		end
	end

	// ---- sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
			ST_SCAN:   if (cnt_last) state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = need_touch ? ST_TOUCH : ST_DONE;
			ST_TOUCH:  if (cnt_last) state_nxt = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:   ctrl.in_ready = 1'b1;
			ST_SCAN:   ctrl.scan     = 1'b1;
			ST_DECIDE: ctrl.decide   = 1'b1;
			ST_TOUCH:  ctrl.touch    = 1'b1;
			ST_DONE:   ctrl.done     = 1'b1;
			default:   ctrl = '0;
		endcase
	end

	assign in_ready = ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// ---- pass counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (ctrl.scan || ctrl.touch) && issue;
			if (ctrl.scan || ctrl.touch) begin
				cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	// ---- item latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
	end

	// ---- scan: one key compare per cycle, plus free and oldest tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			old_any_q  <= 1'b0;
		end else if (in_valid && in_ready) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			old_any_q  <= 1'b0;
		end else if (ctrl.scan && rd_vld_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!hit_q && key_rdata == key_q) begin
					hit_q <= 1'b1;
				end
				if (!old_any_q || age_rdata > old_age_q) begin
					old_any_q <= 1'b1;
				end
			end else if (!free_any_q) begin
				free_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan && rd_vld_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!hit_q && key_rdata == key_q) begin
					hit_idx_q <= rd_idx_s1;
					hit_age_q <= age_rdata;
				end
				if (!old_any_q || age_rdata > old_age_q) begin
					old_idx_q <= rd_idx_s1;
					old_age_q <= age_rdata;
				end
			end else if (!free_any_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// ---- decide: allocation, occupancy, touch setup, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (ctrl.decide && put_new) begin
			valid_q[slot_sel] <= 1'b1;
			occ_q             <= occ_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			slot_q      <= slot_sel;
			thr_q       <= hit_q ? hit_age_q : old_age_q;
			touch_all_q <= put_new;
			res_found_q <= hit_q;
			res_evict_q <= evict;
			res_value_q <= (op_q == OP_PUT) ? value_q : MISS_VALUE;
		end else if (ctrl.touch && cnt_q == '0 && op_q == OP_GET) begin
			// data read issued in the decide cycle lands now
			res_value_q <= data_rdata;
		end
	end

	// ---- touch: ranks below the threshold age by one (every valid rank on a new-entry put), the slot becomes 0
	always_comb begin
		age_we    = 1'b0;
		age_wdata = '0;
		if (ctrl.touch && rd_vld_s1) begin
			if (rd_idx_s1 == slot_q) begin
				age_we = 1'b1;
			end else if (valid_q[rd_idx_s1] && (touch_all_q || age_rdata < thr_q)) begin
				age_we    = 1'b1;
				age_wdata = age_rdata + IW'(1);
			end
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done && (!out_valid_q || out_ready)) begin
			out_found_q <= res_found_q;
			out_evict_q <= res_evict_q;
			out_value_q <= res_value_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign evicted    = out_evict_q;
	assign read_value = out_value_q;

	// ---- entry storage
	lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (ctrl.decide && op_q == OP_PUT && !hit_q),
		.waddr (slot_sel),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
		.clk   (clk),
		.we    (ctrl.decide && op_q == OP_PUT),
		.waddr (slot_sel),
		.wdata (value_q),
		.raddr (slot_sel),
		.rdata (data_rdata)
	);

	lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (rd_idx_s1),
		.wdata (age_wdata),
		.raddr (rd_addr),
		.rdata (age_rdata)
	);

	// ---- checks
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy count disagrees with valid bits");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= LAST)
		else $error("occupancy above entry count");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (occ_q == $past(occ_q) || occ_q == $past(occ_q) + CW'(1)))
		else $error("occupancy moved by more than one");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_found_q && out_evict_q))
		else $error("result both found and evicted");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a second item while one is in progress");

endmodule

// File: rtl/lkvc_ram.sv
module lkvc_ram import lkvc_pkg::*; #(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = ENTRIES_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
